[sv/uer_pkg.sv]
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  // default width of the phase tick counter
  localparam int COUNT_BITS_DEF = 24;

  // field widths
  localparam int TRIG_W   = 16;
  localparam int PAUSE_W  = 24;
  localparam int SCALE_W  = 16;
  localparam int TMO_W    = 24;
  localparam int TICKS_W  = 24;
  localparam int DIST_W   = 22;
  localparam int PROD_W   = TICKS_W + SCALE_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // register reset values
  localparam logic [TRIG_W-1:0]  TRIG_RST  = TRIG_W'(12);
  localparam logic [PAUSE_W-1:0] PAUSE_RST = PAUSE_W'(500000);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(14050);
  localparam logic [TMO_W-1:0]   TMO_RST   = {TMO_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_MEASURE = 2'd2,
    PH_PAUSE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_ticks;
    logic [PAUSE_W-1:0] pause_ticks;
    logic [SCALE_W-1:0] distance_scale;
    logic [TMO_W-1:0]   timeout_ticks;
  } uer_cfg_t;

  typedef struct packed {
    logic               trigger_level;
    logic               result_valid;
    logic               timed_out;
    logic [TICKS_W-1:0] echo_ticks;
    logic [DIST_W-1:0]  distance_centi;
  } uer_result_t;

endpackage

[sv/uer_item_if.sv]
// ----------------------------------------------------------------------------
// uer_item_if
// Tick channel carrying the sampled echo level.
// ----------------------------------------------------------------------------
interface uer_item_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

[sv/uer_result_if.sv]
// ----------------------------------------------------------------------------
// uer_result_if
// Per-tick result channel: trigger drive and measurement result.
// ----------------------------------------------------------------------------
interface uer_result_if
  import uer_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               trigger_level;
  logic               result_valid;
  logic               timed_out;
  logic [TICKS_W-1:0] echo_ticks;
  logic [DIST_W-1:0]  distance_centi;

  modport source (output valid, output trigger_level, output result_valid,
                  output timed_out, output echo_ticks, output distance_centi,
                  input ready);
  modport sink   (input valid, input trigger_level, input result_valid,
                  input timed_out, input echo_ticks, input distance_centi,
                  output ready);
endinterface

[sv/uer_cfg_if.sv]
// ----------------------------------------------------------------------------
// uer_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface uer_cfg_if
  import uer_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[sv/ultrasonic_echo_ranger.sv]
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger/echo ultrasonic sensor controller with echo width and distance.
// ----------------------------------------------------------------------------
// usage
//   item_i   : one transaction per timer tick, carrying the sampled echo level
//   result_o : one transaction per tick: trigger drive, and when a
//              measurement ends, the echo width in ticks, the distance in
//              hundredths of a centimetre and a timeout flag
//   cfg_i    : register writes (trigger, pause, scale, timeout), always
//              ready; write only while no tick is in flight
// latency: a tick accepted at one edge has its result in the output
//   register after the next edge, so 1 cycle from accept to result valid
// throughput: one tick per cycle; the phase/counter update and the
//   24x16 distance multiply sit between the input and output registers
// stall: the output register holds its result while result_o.ready is low,
//   the input register keeps one more tick, then item_i.ready drops
// reset: phase goes to trigger with a zero counter, registers take their
//   defaults (12, 500000, 14050, all ones), no transaction is pending
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  uer_item_if.sink     item_i,
  uer_result_if.source result_o,
  uer_cfg_if.sink      cfg_i
);

  uer_cfg_t    cfg;
  uer_result_t step_res;

  // input register stage
  logic        s1_valid_q, s1_valid_d;
  logic        s1_echo_q;

  // output register stage
  logic        out_valid_q, out_valid_d;
  uer_result_t out_q;

  logic        out_free;
  logic        advance;
  logic        accept;

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || result_o.ready;
  // the tick in the input register is processed when it can move on
  assign advance  = s1_valid_q && out_free;
  assign item_i.ready = !s1_valid_q || out_free;
  assign accept   = item_i.valid && item_i.ready;

  assign s1_valid_d  = accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !result_o.ready);

  uer_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // phase state only moves when a tick advances to the output register
  uer_seq #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .echo_i (s1_echo_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_echo_q <= item_i.echo_level;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.trigger_level  = out_q.trigger_level;
  assign result_o.result_valid   = out_q.result_valid;
  assign result_o.timed_out      = out_q.timed_out;
  assign result_o.echo_ticks     = out_q.echo_ticks;
  assign result_o.distance_centi = out_q.distance_centi;

`ifndef SYNTHESIS
  a_no_trigger_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.result_valid |-> !out_q.trigger_level)
    else $error("result reported during trigger phase");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.result_valid |->
      !out_q.timed_out && out_q.echo_ticks == '0 && out_q.distance_centi == '0)
    else $error("result fields not cleared on a tick without result");

  a_echo_width_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.result_valid |-> out_q.echo_ticks != '0)
    else $error("finished measurement with zero echo width");
`endif

endmodule

[sv/uer_cfg_regs.sv]
// ----------------------------------------------------------------------------
// uer_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module uer_cfg_regs
  import uer_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  uer_cfg_if.sink        cfg_i,
  output uer_cfg_t       cfg_o
);

  uer_cfg_t cfg_q;
  uer_cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_TRIGGER_TICKS:  cfg_d.trigger_ticks  = cfg_i.wr_data[TRIG_W-1:0];
        REG_PAUSE_TICKS:    cfg_d.pause_ticks    = cfg_i.wr_data[PAUSE_W-1:0];
        REG_DISTANCE_SCALE: cfg_d.distance_scale = cfg_i.wr_data[SCALE_W-1:0];
        REG_TIMEOUT_TICKS:  cfg_d.timeout_ticks  = cfg_i.wr_data[TMO_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks  <= TRIG_RST;
      cfg_q.pause_ticks    <= PAUSE_RST;
      cfg_q.distance_scale <= SCALE_RST;
      cfg_q.timeout_ticks  <= TMO_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[sv/uer_seq.sv]
// ----------------------------------------------------------------------------
// uer_seq
// Measurement phase sequencer with echo width counter and distance scaling.
// ----------------------------------------------------------------------------
module uer_seq
  import uer_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        echo_i,
  input  uer_cfg_t    cfg_i,
  output uer_result_t res_o
);

  localparam int CMP_W = (COUNT_BITS > TMO_W) ? COUNT_BITS : TMO_W;
  localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'({COUNT_BITS{1'b1}});
  localparam logic [CMP_W-1:0] ONE     = CMP_W'(1);

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  logic [CMP_W-1:0]      cnt_x, tmo_x, lim, trig_x, pause_x;
  logic [CMP_W-1:0]      meas_inc, pause_inc, meas_cnt, ticks_sat;
  logic [COUNT_BITS-1:0] trig_inc;
  logic                  trig_done, pause_done, finish, tmo_hit;
  phase_e                after_finish;
  logic [PROD_W-1:0]     prod;
  logic [TICKS_W-1:0]    ticks;
  logic [TICKS_W-1:0]    dist_raw;

  // limits and incremented counts
  always_comb begin
    cnt_x   = CMP_W'(count_q);
    tmo_x   = CMP_W'(cfg_i.timeout_ticks);
    trig_x  = CMP_W'(cfg_i.trigger_ticks);
    pause_x = CMP_W'(cfg_i.pause_ticks);
    if (tmo_x == '0) begin
      lim = ONE;
    end else if (tmo_x > CNT_MAX) begin
      lim = CNT_MAX;
    end else begin
      lim = tmo_x;
    end
    trig_inc  = count_q + COUNT_BITS'(1);
    meas_inc  = (cnt_x < lim) ? cnt_x + ONE : cnt_x;
    pause_inc = (cnt_x < CNT_MAX) ? cnt_x + ONE : cnt_x;
    trig_done  = (CMP_W'(trig_inc) >= trig_x) || (trig_inc == '0);
    pause_done = (pause_inc >= pause_x) || (pause_inc >= CNT_MAX);
    after_finish = (cfg_i.pause_ticks == '0) ? PH_TRIGGER : PH_PAUSE;
  end

  // end of measurement decode
  always_comb begin
    finish   = 1'b0;
    tmo_hit  = 1'b0;
    meas_cnt = cnt_x;
    unique case (phase_q)
      PH_WAIT: begin
        meas_cnt = ONE;
        finish   = echo_i && (lim <= ONE);
        tmo_hit  = 1'b1;
      end
      PH_MEASURE: begin
        if (!echo_i) begin
          finish = 1'b1;
        end else begin
          meas_cnt = meas_inc;
          finish   = meas_inc >= lim;
          tmo_hit  = 1'b1;
        end
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    if (step_i) begin
      unique case (phase_q)
        PH_TRIGGER: begin
          if (trig_done) begin
            count_d = '0;
            phase_d = PH_WAIT;
          end else begin
            count_d = trig_inc;
          end
        end
        PH_WAIT: begin
          if (echo_i) begin
            if (finish) begin
              count_d = '0;
              phase_d = after_finish;
            end else begin
              count_d = COUNT_BITS'(1);
              phase_d = PH_MEASURE;
            end
          end
        end
        PH_MEASURE: begin
          if (finish) begin
            count_d = '0;
            phase_d = after_finish;
          end else begin
            count_d = COUNT_BITS'(meas_inc);
          end
        end
        PH_PAUSE: begin
          if (pause_done) begin
            count_d = '0;
            phase_d = PH_TRIGGER;
          end else begin
            count_d = COUNT_BITS'(pause_inc);
          end
        end
        default: begin
          phase_d = PH_TRIGGER;
        end
      endcase
    end
  end

  // result fields; width is bounded by the limit, so it fits the ticks field
  assign ticks_sat = (meas_cnt > lim) ? lim : meas_cnt;
  assign ticks     = TICKS_W'(ticks_sat);
  assign prod      = PROD_W'(ticks) * PROD_W'(cfg_i.distance_scale);
  assign dist_raw  = prod[PROD_W-1:SCALE_W];

  always_comb begin
    res_o = '0;
    res_o.trigger_level = (phase_q == PH_TRIGGER);
    if (finish) begin
      res_o.result_valid   = 1'b1;
      res_o.timed_out      = tmo_hit;
      res_o.echo_ticks     = ticks;
      res_o.distance_centi = (|dist_raw[TICKS_W-1:DIST_W]) ? DIST_MAX
                                                           : dist_raw[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TRIGGER;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_measure_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_MEASURE |-> count_q != '0)
    else $error("echo counter is zero while measuring");

  a_wait_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WAIT |-> count_q == '0)
    else $error("counter not cleared while waiting for echo");

  a_pause_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAUSE |=> phase_q == PH_PAUSE || phase_q == PH_TRIGGER)
    else $error("pause left to a phase other than trigger");
`endif

endmodule

[dv/ultrasonic_echo_ranger_tb.sv]
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_tb
// Self-checking bench for the echo ranger. A queue of echo samples feeds a
// tick driver. A result monitor compares every output transaction with a
// per-tick prediction of the trigger, wait, measure and pause phases.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;

  // longest legal stretch with no transaction is the forced output hold
  localparam int LONG_HOLD   = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_PHASES = 16;
  localparam int PHASE_TICKS = 44;

  localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

  // how often a side idles: never, now and then, or a random gap after each transaction
  typedef enum int {
    PACE_FULL,
    PACE_SPARSE,
    PACE_RANDOM
  } pace_e;

  logic clk_i;
  logic rst_ni;

  uer_item_if   item_if ();
  uer_result_if result_if ();
  uer_cfg_if    cfg_if ();

  ultrasonic_echo_ranger u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // 10 unit clock period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ranger state as the bench sees it, advanced once per accepted tick
  uer_cfg_t                  ranger_cfg;
  phase_e                    ranger_phase;
  logic [COUNT_BITS_DEF-1:0] ranger_count;

  // echo samples waiting to be driven, results owed by the block
  logic        echo_pending[$];
  uer_result_t tick_results_due[$];

  pace_e tx_pace;
  pace_e rx_pace;
  int    tx_gap;
  int    rx_stall;
  int    rx_hold;
  int    hold_request;

  int ticks_queued;
  int ticks_accepted;
  int results_seen;
  int ranges_seen;
  int timeouts_seen;
  int errors;
  int quiet_cycles;

  uer_result_t rx_want;

  function automatic int wait_draw(input pace_e pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_SPARSE: return ($urandom_range(7) == 0) ? $urandom_range(16, 1) : 0;
      default:     return $urandom_range(16);
    endcase
  endfunction

  // echo count limit: a zero limit acts as one, and the counter width caps it
  function automatic logic [COUNT_BITS_DEF-1:0] echo_limit();
    logic [31:0] lim;
    lim = 32'(ranger_cfg.timeout_ticks);
    if (lim == 32'd0) lim = 32'd1;
    if (lim > 32'(COUNT_MAX)) lim = 32'(COUNT_MAX);
    return COUNT_BITS_DEF'(lim);
  endfunction

  // end of a measurement: report width and distance, then go to pause, or to trigger when the pause is zero
  function automatic uer_result_t close_measurement(input logic hit_limit);
    uer_result_t               r;
    logic [COUNT_BITS_DEF-1:0] span;
    logic [PROD_W-1:0]         prod;
    r = '0;
    span = ranger_count;
    if (span > echo_limit()) span = echo_limit();
    prod = PROD_W'(span) * PROD_W'(ranger_cfg.distance_scale);
    prod = prod >> 16;
    r.result_valid   = 1'b1;
    r.timed_out      = hit_limit;
    r.echo_ticks     = TICKS_W'(span);
    r.distance_centi = (prod > PROD_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(prod);
    ranger_count = '0;
    ranger_phase = (ranger_cfg.pause_ticks == '0) ? PH_TRIGGER : PH_PAUSE;
    return r;
  endfunction

  // one timer tick; all limits are tested with >= so a lowered register
  // ends the running phase at once
  function automatic uer_result_t range_tick(input logic echo);
    uer_result_t r;
    r = '0;
    case (ranger_phase)
      PH_TRIGGER: begin
        r.trigger_level = 1'b1;
        ranger_count = ranger_count + 1'b1;
        // a zero trigger length still gives one trigger tick
        if (ranger_count >= ranger_cfg.trigger_ticks || ranger_count == '0) begin
          ranger_count = '0;
          ranger_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        // level, not edge; no timeout while waiting
        if (echo) begin
          ranger_count = COUNT_BITS_DEF'(1);
          ranger_phase = PH_MEASURE;
          if (ranger_count >= echo_limit()) r = close_measurement(1'b1);
        end
      end
      PH_MEASURE: begin
        if (!echo) begin
          r = close_measurement(1'b0);
        end else begin
          if (ranger_count < echo_limit()) ranger_count = ranger_count + 1'b1;
          if (ranger_count >= echo_limit()) r = close_measurement(1'b1);
        end
      end
      default: begin
        if (ranger_count < COUNT_MAX) ranger_count = ranger_count + 1'b1;
        if (ranger_count >= ranger_cfg.pause_ticks || ranger_count >= COUNT_MAX) begin
          ranger_count = '0;
          ranger_phase = PH_TRIGGER;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      end
    end
  endfunction

  // tick driver: predicts on every accepted transaction, then offers the
  // next queued sample after its drawn gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_if.valid      <= 1'b0;
      item_if.echo_level <= 1'b0;
      tx_gap = 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        tick_results_due.push_back(range_tick(item_if.echo_level));
        ticks_accepted++;
      end
      if (!item_if.valid || item_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          item_if.valid <= 1'b0;
        end else if (echo_pending.size() > 0) begin
          item_if.valid      <= 1'b1;
          item_if.echo_level <= echo_pending.pop_front();
          tx_gap = wait_draw(tx_pace);
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each transaction against the oldest prediction;
  // ready drops for a drawn stall after each one, or for a requested hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      rx_stall = 0;
      rx_hold  = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        results_seen++;
        if (tick_results_due.size() == 0) begin
          errors++;
          $display("%0t: result transaction with no tick outstanding", $time);
        end else begin
          rx_want = tick_results_due.pop_front();
          compare_field("trigger_level", rx_want.trigger_level, result_if.trigger_level);
          compare_field("result_valid", rx_want.result_valid, result_if.result_valid);
          compare_field("timed_out", rx_want.timed_out, result_if.timed_out);
          compare_field("echo_ticks", rx_want.echo_ticks, result_if.echo_ticks);
          compare_field("distance_centi", rx_want.distance_centi, result_if.distance_centi);
          if (rx_want.result_valid) ranges_seen++;
          if (rx_want.timed_out) timeouts_seen++;
        end
        rx_stall = wait_draw(rx_pace);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      if (hold_request > 0) begin
        rx_hold = hold_request;
        hold_request = 0;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      result_if.ready <= (rx_stall == 0) && (rx_hold == 0);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("ultrasonic_echo_ranger_tb: done, errors");
      $finish;
    end
  end

  // one register write; valid stays high for a following write
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_TRIGGER_TICKS:  ranger_cfg.trigger_ticks  = data[TRIG_W-1:0];
      REG_PAUSE_TICKS:    ranger_cfg.pause_ticks    = data[PAUSE_W-1:0];
      REG_DISTANCE_SCALE: ranger_cfg.distance_scale = data[SCALE_W-1:0];
      REG_TIMEOUT_TICKS:  ranger_cfg.timeout_ticks  = data[TMO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input uer_cfg_t c);
    write_setting(REG_TRIGGER_TICKS, CFG_DATA_W'(c.trigger_ticks));
    write_setting(REG_PAUSE_TICKS, CFG_DATA_W'(c.pause_ticks));
    write_setting(REG_DISTANCE_SCALE, CFG_DATA_W'(c.distance_scale));
    write_setting(REG_TIMEOUT_TICKS, CFG_DATA_W'(c.timeout_ticks));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic queue_level(input int n, input logic lvl);
    repeat (n) echo_pending.push_back(lvl);
    ticks_queued += n;
  endtask

  // alternating low and high runs, so most highs land in a measurement;
  // about one run in ten is line noise
  task automatic queue_echo_train(input int n, input int high_max);
    int   run;
    logic lvl;
    lvl = 1'b0;
    while (n > 0) begin
      run = lvl ? $urandom_range(high_max, 1) : $urandom_range(6, 0);
      if (run > n) run = n;
      if ($urandom_range(9) == 0) begin
        repeat (run) echo_pending.push_back(1'($urandom_range(1)));
      end else begin
        repeat (run) echo_pending.push_back(lvl);
      end
      ticks_queued += run;
      n -= run;
      lvl = ~lvl;
    end
  endtask

  // sender holds off until every tick is accepted and answered, then lets
  // the pipeline settle
  task automatic drain();
    do @(posedge clk_i);
    while (ticks_accepted != ticks_queued || tick_results_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    uer_cfg_t c;
    rst_ni              = 1'b0;
    item_if.valid       = 1'b0;
    item_if.echo_level  = 1'b0;
    result_if.ready     = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.reg_index    = '0;
    cfg_if.wr_data      = '0;
    tx_pace             = PACE_RANDOM;
    rx_pace             = PACE_RANDOM;
    hold_request        = 0;
    ticks_queued        = 0;
    ticks_accepted      = 0;
    results_seen        = 0;
    ranges_seen         = 0;
    timeouts_seen       = 0;
    errors              = 0;
    quiet_cycles        = 0;
    ranger_cfg          = '{TRIG_RST, PAUSE_RST, SCALE_RST, TMO_RST};
    ranger_phase        = PH_TRIGGER;
    ranger_count        = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: echo already high at the end of the trigger, so the
    // wait sees the level at once and the first high tick counts as one;
    // finishes early in the long default pause
    queue_level(9, 1'b0);
    queue_level(3, 1'b1);
    queue_level(4, 1'b1);
    queue_level(1, 1'b0);
    queue_level(2, 1'b0);
    drain();

    // zero trigger, zero pause and zero timeout; the new zero pause ends the
    // pause that is under way, and every echo times out on its first tick
    c = '{TRIG_W'(0), PAUSE_W'(0), SCALE_W'(16'hFFFF), TMO_W'(0)};
    load_settings(c);
    queue_level(2, 1'b0);
    queue_level(1, 1'b1);
    queue_level(2, 1'b0);
    queue_level(1, 1'b1);
    drain();

    // pause, scale and timeout at their maximums with a long echo, no idling;
    // the pause never runs out here and the next write cuts it short
    tx_pace = PACE_FULL;
    rx_pace = PACE_FULL;
    c = '{TRIG_W'(4), PAUSE_W'(24'hFFFFFF), SCALE_W'(16'hFFFF), TMO_W'(24'hFFFFFF)};
    load_settings(c);
    queue_level(4, 1'b0);
    queue_level(3, 1'b0);
    queue_level(150, 1'b1);
    queue_level(21, 1'b0);
    drain();

    // random settings and echo trains; one phase holds the result side off
    // for a long stretch while ticks keep coming, to fill and stall the block
    for (int p = 0; p < RAND_PHASES; p++) begin
      tx_pace = pace_e'($urandom_range(2));
      rx_pace = pace_e'($urandom_range(2));
      c.trigger_ticks  = TRIG_W'($urandom_range(8));
      c.pause_ticks    = PAUSE_W'($urandom_range(12));
      c.distance_scale = SCALE_W'($urandom);
      c.timeout_ticks  = $urandom_range(1) ? TMO_W'($urandom_range(40, 1)) : TMO_W'($urandom);
      load_settings(c);
      if (p == 5) begin
        tx_pace = PACE_FULL;
        hold_request = LONG_HOLD;
      end
      queue_echo_train(PHASE_TICKS, $urandom_range(40, 4));
      drain();
    end

    $display("summary: %0d ticks driven, %0d results checked, %0d ranges, %0d timed out",
             ticks_accepted, results_seen, ranges_seen, timeouts_seen);
    $display("summary: reset defaults, zero and maximum registers, long output hold, %0d phases",
             RAND_PHASES + 3);
    if (errors == 0) begin
      $display("ultrasonic_echo_ranger_tb: done, clean");
    end else begin
      $display("ultrasonic_echo_ranger_tb: done, errors");
    end
    $finish;
  end

endmodule
